[rtl/joystick_debounce_hold_repeat_unit_assert.svh]
// Assertion macros for the joystick debounce block.
// Used by the top level only; relies on clk and arst_n being in scope.
`ifndef JOYSTICK_DEBOUNCE_HOLD_REPEAT_UNIT_ASSERT_SVH
`define JOYSTICK_DEBOUNCE_HOLD_REPEAT_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define JDHR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define JDHR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/jdhr_pkg.sv]
// Shared types and constants for the joystick debounce block.
// No dependencies; imported by every module of the block.
package jdhr_pkg;

	localparam int unsigned AddrWidth = 4;
	localparam int unsigned DataWidth = 32;
	localparam int unsigned CfgWidth  = 16;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
	localparam logic [1:0] REG_HOLD      = 2'd1;
	localparam logic [1:0] REG_LONG_HOLD = 2'd2;
	localparam logic [1:0] REG_REPEAT    = 2'd3;

	localparam logic [CfgWidth-1:0] DEBOUNCE_RST  = 16'd5;
	localparam logic [CfgWidth-1:0] HOLD_RST      = 16'd800;
	localparam logic [CfgWidth-1:0] LONG_HOLD_RST = 16'd3500;
	localparam logic [CfgWidth-1:0] REPEAT_RST    = 16'd500;

	localparam logic [2:0] CODE_NONE   = 3'd0;
	localparam logic [2:0] CODE_CENTER = 3'd1;
	localparam logic [2:0] CODE_DOWN   = 3'd2;
	localparam logic [2:0] CODE_LEFT   = 3'd3;
	localparam logic [2:0] CODE_RIGHT  = 3'd4;
	localparam logic [2:0] CODE_UP     = 3'd5;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_PRESSED   = 3'd1;
	localparam logic [2:0] EV_RELEASED  = 3'd2;
	localparam logic [2:0] EV_HELD      = 3'd3;
	localparam logic [2:0] EV_HELD_LONG = 3'd4;

	typedef struct packed {
		logic [4:0]  pin_levels;
		logic [31:0] now_ms;
	} poll_word_t;

	typedef struct packed {
		logic [2:0]  button_code;
		logic [2:0]  event_kind;
		logic [15:0] hold_count;
	} result_word_t;

	typedef struct packed {
		logic [CfgWidth-1:0] debounce_ms;
		logic [CfgWidth-1:0] hold_ms;
		logic [CfgWidth-1:0] long_hold_ms;
		logic [CfgWidth-1:0] repeat_ms;
	} cfg_t;

	// priority: center, down, left, right, up
	function automatic logic [2:0] encode_pins(input logic [4:0] pins);
		logic [2:0] code;
		code = CODE_NONE;
		if (pins[4])      code = CODE_CENTER;
		else if (pins[1]) code = CODE_DOWN;
		else if (pins[2]) code = CODE_LEFT;
		else if (pins[3]) code = CODE_RIGHT;
		else if (pins[0]) code = CODE_UP;
		return code;
	endfunction

endpackage

[rtl/jdhr_cfg_regs.sv]
// APB-style register file for the debounce, hold, long-hold and repeat times.
// Depends on jdhr_pkg.
module jdhr_cfg_regs
	import jdhr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms  <= DEBOUNCE_RST;
			cfg_q.hold_ms      <= HOLD_RST;
			cfg_q.long_hold_ms <= LONG_HOLD_RST;
			cfg_q.repeat_ms    <= REPEAT_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_DEBOUNCE:  cfg_q.debounce_ms  <= pwdata[CfgWidth-1:0];
				REG_HOLD:      cfg_q.hold_ms      <= pwdata[CfgWidth-1:0];
				REG_LONG_HOLD: cfg_q.long_hold_ms <= pwdata[CfgWidth-1:0];
				REG_REPEAT:    cfg_q.repeat_ms    <= pwdata[CfgWidth-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_DEBOUNCE:  prdata[CfgWidth-1:0] = cfg_q.debounce_ms;
			REG_HOLD:      prdata[CfgWidth-1:0] = cfg_q.hold_ms;
			REG_LONG_HOLD: prdata[CfgWidth-1:0] = cfg_q.long_hold_ms;
			REG_REPEAT:    prdata[CfgWidth-1:0] = cfg_q.repeat_ms;
			default:       prdata = '0;
		endcase
	end

endmodule

[rtl/jdhr_event_core.sv]
// Debounce, hold detection and repeat gating: press state plus the
// single-pass logic that turns one registered poll into one result.
// Depends on jdhr_pkg.
module jdhr_event_core
	import jdhr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  poll_word_t   poll,
	input  logic         advance,
	output result_word_t result
);

	logic [2:0]  cand_code_q;
	logic [31:0] cand_since_q;
	logic [2:0]  stable_code_q;
	logic        was_held_q;
	logic [15:0] hold_cnt_q;
	logic [15:0] last_action_q;

	logic [2:0]  code;
	logic        changed;
	logic [31:0] duration;
	logic        settled;
	logic [15:0] gap;
	logic [2:0]  ev;
	logic [2:0]  button;
	logic        was_held_d;
	logic [15:0] hold_cnt_d;
	logic [15:0] last_action_d;
	logic [2:0]  stable_code_d;

	assign code     = encode_pins(poll.pin_levels);
	assign changed  = (code != cand_code_q);
	assign duration = poll.now_ms - cand_since_q;
	assign settled  = !changed && (duration >= {16'd0, cfg.debounce_ms});
	assign gap      = poll.now_ms[15:0] - last_action_q;

	always_comb begin
		ev            = EV_NONE;
		button        = CODE_NONE;
		was_held_d    = was_held_q;
		hold_cnt_d    = hold_cnt_q;
		last_action_d = last_action_q;
		stable_code_d = stable_code_q;
		if (!settled) begin
			hold_cnt_d = '0;
		end else begin
			button        = code;
			stable_code_d = code;
			if (code != stable_code_q) begin
				hold_cnt_d = '0;
				if (code != CODE_NONE) begin
					ev = EV_PRESSED;
				end else begin
					// a release after a hold goes unreported
					if (!was_held_q) begin
						ev     = EV_RELEASED;
						button = stable_code_q;
					end
					was_held_d = 1'b0;
				end
			end else if (code != CODE_NONE) begin
				if (duration >= {16'd0, cfg.long_hold_ms}) begin
					ev = EV_HELD_LONG;
				end else if (duration >= {16'd0, cfg.hold_ms}) begin
					ev         = EV_HELD;
					was_held_d = 1'b1;
				end
				if (ev != EV_NONE) begin
					if (gap < cfg.repeat_ms) begin
						ev = EV_NONE;
					end else begin
						hold_cnt_d    = hold_cnt_q + 16'd1;
						last_action_d = poll.now_ms[15:0];
					end
				end
			end
		end
	end

	assign result.button_code = button;
	assign result.event_kind  = ev;
	assign result.hold_count  = hold_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_code_q   <= CODE_NONE;
			cand_since_q  <= '0;
			stable_code_q <= CODE_NONE;
			was_held_q    <= 1'b0;
			hold_cnt_q    <= '0;
			last_action_q <= '0;
		end else if (advance) begin
			if (changed) begin
				cand_code_q  <= code;
				cand_since_q <= poll.now_ms;
			end
			stable_code_q <= stable_code_d;
			was_held_q    <= was_held_d;
			hold_cnt_q    <= hold_cnt_d;
			last_action_q <= last_action_d;
		end
	end

endmodule

[rtl/joystick_debounce_hold_repeat_unit.sv]
// Joystick debounce with hold and auto-repeat, one result word per poll word.
// The poll word is captured in an input register, then its result in the result
// register. Throughput: one word per cycle while result_ready is high, set by the
// state update in jdhr_event_core; a full, unread result register stalls input.
// Reset: press state cleared, registers at their default times, both
// stages empty. Depends on jdhr_pkg, jdhr_cfg_regs and jdhr_event_core.
module joystick_debounce_hold_repeat_unit
	import jdhr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 poll_valid,
	output logic                 poll_ready,
	input  poll_word_t           poll,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_word_t         result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [DataWidth-1:0] pwdata,
	output logic [DataWidth-1:0] prdata,
	output logic                 pready
);

`include "joystick_debounce_hold_repeat_unit_assert.svh"

	cfg_t         cfg;
	poll_word_t   poll_s1;
	logic         valid_s1;
	result_word_t core_result;
	result_word_t result_q;
	logic         result_valid_q;
	logic         advance;

	jdhr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	jdhr_event_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.poll    (poll_s1),
		.advance (advance),
		.result  (core_result)
	);

	// the staged word moves on whenever the result register is free or draining
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign poll_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (poll_ready) valid_s1 <= poll_valid;
			if (advance) result_valid_q <= 1'b1;
			else if (result_ready) result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && poll_ready) poll_s1 <= poll;
		if (advance) result_q <= core_result;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`JDHR_ASSERT_IMPL(a_no_overrun, valid_s1 && result_valid_q && !result_ready, !poll_ready, "poll word taken while both stages are blocked")
	`JDHR_ASSERT_IMPL(a_release_has_button, result_valid && result.event_kind == EV_RELEASED, result.button_code != CODE_NONE, "release word without a button")
	`JDHR_ASSERT_IMPL(a_press_clears_count, result_valid && result.event_kind == EV_PRESSED, result.hold_count == 16'd0, "press word with non-zero hold count")
	`JDHR_ASSERT_NEXT(a_result_loaded, advance, result_valid, "staged word lost on its way to the result register")

endmodule
